// ===== hdl/icfc_pkg.sv =====
// ----------------------------------------------------------------------------
// icfc_pkg
// Shared types and constants of the interval containment failure cache.
// ----------------------------------------------------------------------------
`default_nettype none
package icfc_pkg;
  localparam int unsigned OpBits  = 1;
  localparam int unsigned LenBits = 4;
  localparam int unsigned CapBits = 5;
  localparam logic [CapBits-1:0] CapReset = 5'd17;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_e;

  typedef enum logic {
    ST_DONE    = 1'b0,
    ST_BAD_LEN = 1'b1
  } status_e;
endpackage
`default_nettype wire

// ===== hdl/icfc_if.sv =====
// ----------------------------------------------------------------------------
// icfc_in_if / icfc_out_if
// Valid/ready channels of the cache: key intervals in, lookup results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface icfc_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  logic [3:0]          key_length;
  logic [15:0]         interval_start;
  logic [15:0]         interval_end;
  modport source (output valid, op, key_length, interval_start, interval_end,
                  input ready);
  modport sink   (input valid, op, key_length, interval_start, interval_end,
                  output ready);
endinterface

interface icfc_out_if;
  logic valid;
  logic ready;
  logic found;
  logic status;
  modport source (output valid, found, status, input ready);
  modport sink   (input valid, found, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/icfc_cmp.sv =====
// ----------------------------------------------------------------------------
// icfc_cmp
// Shared containment compare: stored interval holds query interval.
// ----------------------------------------------------------------------------
`default_nettype none
module icfc_cmp #(
  parameter int unsigned TimeBits = 16
) (
  input  wire logic [TimeBits-1:0] q_lo_i,
  input  wire logic [TimeBits-1:0] q_hi_i,
  input  wire logic [TimeBits-1:0] s_lo_i,
  input  wire logic [TimeBits-1:0] s_hi_i,
  output logic                     hold_o
);
  assign hold_o = (s_lo_i <= q_lo_i) && (q_hi_i <= s_hi_i);
endmodule
`default_nettype wire

// ===== hdl/interval_containment_failure_cache_core.sv =====
// ----------------------------------------------------------------------------
// interval_containment_failure_cache_core
// An interval of a key is taken each transfer. Items that do not complete a
// key are staged and the next interval can follow at once. A rejected
// length offers its result in the cycle after its transfer. A completing
// insert holds the block while S_WRITE writes the key store one interval per
// step, then S_RESULT posts the result. A completing find walks the stored
// entries of its length class through a single key-store read port and one
// shared compare: S_READ fetches each entry and S_CHECK compares it interval
// by interval; once S_READ sees the class is done, S_RESULT posts the result.
// The input is not ready while a result waits for its transfer. Each length
// class is a FIFO of FIFO_DEPTH slots and holds at most capacity - 1 keys,
// and never more than FIFO_DEPTH. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_containment_failure_cache_core
  import icfc_pkg::*;
#(
  parameter int unsigned MAX_LEN    = 8,
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned TIME_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CapBits-1:0] cfg_wdata_i,
  icfc_in_if.sink                 in_if,
  icfc_out_if.source              out_if
);
  localparam int unsigned EB = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SB = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CB = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SumBits = CB + 1;
  localparam int unsigned CLB = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned AB = CLB + SB + EB;
  localparam int unsigned Depth = 2 ** AB;
  localparam int unsigned LimBits = $clog2(FIFO_DEPTH + 2);

  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_READ, S_CHECK, S_RESULT} state_e;

  state_e             state_q;
  logic [CapBits-1:0] cap_q;
  logic [EB-1:0]      elem_q, step_q;
  logic [EB-1:0]      last_q;
  logic [CLB-1:0]     cls_q;
  logic [CB-1:0]      count_q [MAX_LEN];
  logic [SB-1:0]      head_q [MAX_LEN];
  logic [CB-1:0]      k_q;
  logic               match_q, hit_q, found_q, status_q, valid_q, op_q;
  logic [TIME_BITS-1:0] stg_lo_q [MAX_LEN];
  logic [TIME_BITS-1:0] stg_hi_q [MAX_LEN];
  logic [2*TIME_BITS-1:0] mem [Depth];
  logic [2*TIME_BITS-1:0] rd_q;
  logic [EB-1:0]      rd_e_q;
  logic               hold;

  logic [3:0]  len;
  logic        bad_len;
  logic [4:0]  eidx;
  logic [SumBits-1:0] slot_sum;
  logic [SB-1:0] slot;
  logic [AB-1:0] addr;
  logic [LimBits-1:0] limit;
  logic [CB:0] cnt_inc;

  assign len     = in_if.key_length;
  assign bad_len = (len == 4'd0) || (32'(len) > MAX_LEN);
  assign eidx    = (5'(elem_q) >= 5'(len)) ? 5'd0 : 5'(elem_q);
  assign in_if.ready  = (state_q == S_IDLE) && !valid_q;
  assign out_if.valid = valid_q;
  assign out_if.found = found_q;
  assign out_if.status = status_q;

  assign limit = (32'(cap_q) > FIFO_DEPTH + 1) ? LimBits'(FIFO_DEPTH + 1)
                                               : LimBits'(cap_q);
  assign cnt_inc = {1'b0, count_q[cls_q]} + 1'b1;

  always_comb begin
    if (state_q == S_WRITE) begin
      slot_sum = SumBits'(head_q[cls_q]) + SumBits'(count_q[cls_q]);
    end else begin
      slot_sum = SumBits'(head_q[cls_q]) + SumBits'(k_q);
    end
    if (slot_sum >= SumBits'(FIFO_DEPTH)) begin
      slot = SB'(slot_sum - SumBits'(FIFO_DEPTH));
    end else begin
      slot = SB'(slot_sum);
    end
    addr = {cls_q, slot, step_q};
  end

  icfc_cmp #(.TimeBits(TIME_BITS)) u_cmp (
    .q_lo_i (stg_lo_q[rd_e_q]),
    .q_hi_i (stg_hi_q[rd_e_q]),
    .s_lo_i (rd_q[TIME_BITS-1:0]),
    .s_hi_i (rd_q[2*TIME_BITS-1:TIME_BITS]),
    .hold_o (hold)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      mem[addr] <= {stg_hi_q[step_q], stg_lo_q[step_q]};
    end
    rd_q   <= mem[addr];
    rd_e_q <= step_q;
    if (in_if.valid && in_if.ready && !bad_len) begin
      stg_lo_q[eidx[EB-1:0]] <= TIME_BITS'(in_if.interval_start);
      stg_hi_q[eidx[EB-1:0]] <= TIME_BITS'(in_if.interval_end);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cap_q    <= CapReset;
      elem_q   <= '0;
      step_q   <= '0;
      last_q   <= '0;
      cls_q    <= '0;
      k_q      <= '0;
      match_q  <= 1'b1;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
      valid_q  <= 1'b0;
      op_q     <= 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
        count_q[i] <= '0;
        head_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (valid_q && out_if.ready) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            if (bad_len) begin
              elem_q   <= '0;
              found_q  <= 1'b0;
              status_q <= ST_BAD_LEN;
              valid_q  <= 1'b1;
            end else if (eidx + 5'd1 < 5'(len)) begin
              elem_q <= EB'(eidx + 5'd1);
            end else begin
              elem_q  <= '0;
              cls_q   <= CLB'(len - 4'd1);
              last_q  <= EB'(len - 4'd1);
              step_q  <= '0;
              k_q     <= '0;
              match_q <= 1'b1;
              hit_q   <= 1'b0;
              op_q    <= in_if.op;
              state_q <= (in_if.op == OP_INSERT) ? S_WRITE : S_READ;
            end
          end
        end
        S_WRITE: begin
          if (step_q == last_q) begin
            step_q <= '0;
            if (32'(cnt_inc) >= 32'(limit)) begin
              head_q[cls_q] <= (32'(head_q[cls_q]) == FIFO_DEPTH - 1) ? '0
                                                                     : head_q[cls_q] + 1'b1;
            end else begin
              count_q[cls_q] <= CB'(cnt_inc);
            end
            state_q <= S_RESULT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_READ: begin
          if (k_q >= count_q[cls_q]) begin
            state_q <= S_RESULT;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_e_q == last_q) begin
            if (hold && match_q) begin
              hit_q <= 1'b1;
            end
            match_q <= 1'b1;
            step_q  <= '0;
            k_q     <= k_q + 1'b1;
            state_q <= S_READ;
          end else begin
            match_q <= match_q && hold;
            step_q  <= step_q + 1'b1;
          end
        end
        S_RESULT: begin
          found_q  <= (op_q == OP_FIND) ? hit_q : 1'b0;
          status_q <= ST_DONE;
          valid_q  <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
